// File: rtl/xdm_pkg.sv
// ----------------------------------------------------------------------------
// X-drive mixer package
// Shared widths, payload types, register codes and the unit clamp.
// ----------------------------------------------------------------------------
package xdm_pkg;

    // Fixed field widths
    localparam int CMD_W     = 16;
    localparam int OUT_W     = 16;
    localparam int VOLT_W    = 15;
    localparam int SUM_W     = CMD_W + 2;   // forward +/- yaw, signed
    localparam int MAG_W     = SUM_W - 1;   // magnitude of a mixed value
    localparam int NUM_LANES = 3;
    localparam int NUM_WHEELS = 4;

    // Lane order inside the normalizer
    localparam int LANE_LEFT   = 0;
    localparam int LANE_RIGHT  = 1;
    localparam int LANE_STRAFE = 2;

    // Wheel order inside the back end
    localparam int WHL_FL = 0;
    localparam int WHL_FR = 1;
    localparam int WHL_BR = 2;
    localparam int WHL_BL = 3;

    // Defaults for top-level parameters
    localparam int FRAC_BITS_DEF = 12;
    localparam int DIV_STEPS_DEF = 4;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [VOLT_W-1:0] VOLT_RESET = VOLT_W'(12000);

    typedef enum logic [0:0] {
        REG_MAX_VOLTAGE = 1'b0
    } t_reg_idx;

    typedef struct packed {
        logic signed [CMD_W-1:0] forward_cmd;
        logic signed [CMD_W-1:0] yaw_cmd;
        logic signed [CMD_W-1:0] strafe_cmd;
    } t_cmd;

    typedef struct packed {
        logic signed [OUT_W-1:0] front_left_volts;
        logic signed [OUT_W-1:0] front_right_volts;
        logic signed [OUT_W-1:0] back_right_volts;
        logic signed [OUT_W-1:0] back_left_volts;
    } t_volts;

    // One signed value as sign and magnitude
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_lane;

    // Front end to divider: three magnitudes and the common divisor
    typedef struct packed {
        t_lane [NUM_LANES-1:0] lane;
        logic [MAG_W-1:0]      divisor;
    } t_norm;

    // Clamp to [-1.0, 1.0] for the given number of fraction bits
    function automatic logic signed [SUM_W-1:0] clamp_unit(
        input logic signed [SUM_W-1:0] v,
        input int unsigned             frac_bits
    );
        logic signed [SUM_W-1:0] one;
        one = SUM_W'(1) << frac_bits;
        if (v > one) begin
            return one;
        end else if (v < -one) begin
            return -one;
        end else begin
            return v;
        end
    endfunction

endpackage

// File: rtl/x_drive_motor_mixer.sv
// ----------------------------------------------------------------------------
// X-drive motor mixer
// Mixes forward, yaw and strafe commands into four wheel voltages, with
// normalization when the mix leaves the unit range.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                      | payload
//  --------+-----------+--------------------------------+--------------------
//  command | in        | i_cmd_valid / o_cmd_ready      | i_cmd   (t_cmd)
//  volts   | out       | o_volts_valid / i_volts_ready  | o_volts (t_volts)
//  config  | in        | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
//  Throughput is one command transfer per clock while the volts side does not
//  stall. The pipeline has one front end stage, NSTG = ceil((FRAC_BITS+1) /
//  DIV_STEPS) divider stages and three back end stages.
//  Reset clears every stage valid bit and loads max_voltage with 12000.
//  Each stage holds while its successor is full and stalled, so a stall on
//  the volts side backs up stage by stage and bubbles are squeezed out.
// ----------------------------------------------------------------------------
module x_drive_motor_mixer import xdm_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int DIV_STEPS = DIV_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command channel
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_ready,
    input  t_cmd                  i_cmd,
    // result channel
    output logic                  o_volts_valid,
    input  logic                  i_volts_ready,
    output t_volts                o_volts,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(1) << FRAC_BITS;

    logic [VOLT_W-1:0]     r_max_voltage;
    t_reg_idx              w_reg_idx;
    logic                  w_cfg_wr;

    logic                  w_norm_valid;
    logic                  w_norm_ready;
    t_norm                 w_norm;
    logic                  w_quot_valid;
    logic                  w_quot_ready;
    t_lane [NUM_LANES-1:0] w_quot;

    // ------------------------------------------------------------------
    // Configuration register: word index is paddr above the byte offset
    // ------------------------------------------------------------------
    assign w_reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign w_cfg_wr  = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_voltage <= VOLT_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_MAX_VOLTAGE: r_max_voltage <= pwdata[VOLT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_MAX_VOLTAGE: prdata = APB_DATA_W'(r_max_voltage);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath: front end -> divider -> back end
    // ------------------------------------------------------------------
    xdm_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd_valid),
        .o_ready (o_cmd_ready),
        .i_cmd   (i_cmd),
        .o_valid (w_norm_valid),
        .i_ready (w_norm_ready),
        .o_norm  (w_norm)
    );

    xdm_div #(
        .FRAC_BITS     (FRAC_BITS),
        .STEPS_PER_STG (DIV_STEPS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_norm_valid),
        .o_ready (w_norm_ready),
        .i_norm  (w_norm),
        .o_valid (w_quot_valid),
        .i_ready (w_quot_ready),
        .o_lane  (w_quot)
    );

    xdm_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_max_voltage (r_max_voltage),
        .i_valid       (w_quot_valid),
        .o_ready       (w_quot_ready),
        .i_lane        (w_quot),
        .o_valid       (o_volts_valid),
        .i_ready       (i_volts_ready),
        .o_volts       (o_volts)
    );

`ifndef SYNTHESIS
    // divisor never below 1.0 and never below any lane magnitude
    a_div_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_norm_valid |-> (w_norm.divisor >= ONE_MAG)
            && (w_norm.lane[LANE_LEFT].mag <= w_norm.divisor)
            && (w_norm.lane[LANE_RIGHT].mag <= w_norm.divisor)
            && (w_norm.lane[LANE_STRAFE].mag <= w_norm.divisor))
        else $error("normalizer divisor out of bounds");

    // normalized magnitudes stay within 1.0
    a_quot_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_quot_valid |-> (w_quot[LANE_LEFT].mag <= ONE_MAG)
            && (w_quot[LANE_RIGHT].mag <= ONE_MAG)
            && (w_quot[LANE_STRAFE].mag <= ONE_MAG))
        else $error("divider quotient above 1.0");

    // wheel voltages never exceed full scale
    a_volts_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_volts_valid |->
            ($signed(o_volts.front_left_volts)  <=  $signed({1'b0, r_max_voltage}))
         && ($signed(o_volts.front_left_volts)  >= -$signed({1'b0, r_max_voltage}))
         && ($signed(o_volts.front_right_volts) <=  $signed({1'b0, r_max_voltage}))
         && ($signed(o_volts.front_right_volts) >= -$signed({1'b0, r_max_voltage}))
         && ($signed(o_volts.back_right_volts)  <=  $signed({1'b0, r_max_voltage}))
         && ($signed(o_volts.back_right_volts)  >= -$signed({1'b0, r_max_voltage}))
         && ($signed(o_volts.back_left_volts)   <=  $signed({1'b0, r_max_voltage}))
         && ($signed(o_volts.back_left_volts)   >= -$signed({1'b0, r_max_voltage})))
        else $error("wheel voltage beyond max_voltage");

    // reset loads the full-scale default
    a_cfg_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> r_max_voltage == VOLT_RESET)
        else $error("max_voltage not at reset value");
`endif

endmodule

// File: rtl/xdm_front.sv
// ----------------------------------------------------------------------------
// X-drive mixer front end
// Clamp forward and strafe, form left and right, find the largest magnitude.
// ----------------------------------------------------------------------------
module xdm_front import xdm_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_cmd  i_cmd,
    output logic  o_valid,
    input  logic  i_ready,
    output t_norm o_norm
);

    localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(1) << FRAC_BITS;

    logic                    r_valid;
    t_norm                   r_norm;
    t_norm                   n_norm;
    logic signed [SUM_W-1:0] w_val [NUM_LANES];
    logic [MAG_W-1:0]        w_mag [NUM_LANES];
    logic [MAG_W-1:0]        w_max;

    always_comb begin
        logic signed [SUM_W-1:0] fwd;
        fwd                 = clamp_unit(SUM_W'(i_cmd.forward_cmd), FRAC_BITS);
        w_val[LANE_LEFT]    = fwd + SUM_W'(i_cmd.yaw_cmd);
        w_val[LANE_RIGHT]   = fwd - SUM_W'(i_cmd.yaw_cmd);
        w_val[LANE_STRAFE]  = clamp_unit(SUM_W'(i_cmd.strafe_cmd), FRAC_BITS);
        for (int l = 0; l < NUM_LANES; l++) begin
            w_mag[l] = w_val[l][SUM_W-1] ? MAG_W'(-w_val[l]) : MAG_W'(w_val[l]);
            n_norm.lane[l].neg = w_val[l][SUM_W-1];
            n_norm.lane[l].mag = w_mag[l];
        end
        w_max = w_mag[LANE_LEFT];
        if (w_mag[LANE_RIGHT] > w_max) begin
            w_max = w_mag[LANE_RIGHT];
        end
        if (w_mag[LANE_STRAFE] > w_max) begin
            w_max = w_mag[LANE_STRAFE];
        end
        // dividing by 1.0 passes the value through unchanged
        n_norm.divisor = (w_max > ONE_MAG) ? w_max : ONE_MAG;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_norm <= n_norm;
        end
    end

    assign o_valid = r_valid;
    assign o_norm  = r_norm;

endmodule

// File: rtl/xdm_div.sv
// ----------------------------------------------------------------------------
// X-drive mixer normalizing divider
// Pipelined restoring division of three magnitudes by a shared divisor.
// ----------------------------------------------------------------------------
module xdm_div import xdm_pkg::*; #(
    parameter int FRAC_BITS     = FRAC_BITS_DEF,
    parameter int STEPS_PER_STG = DIV_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_norm                 i_norm,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_lane [NUM_LANES-1:0] o_lane
);

    localparam int NQ   = FRAC_BITS + 1;
    localparam int NSTG = (NQ + STEPS_PER_STG - 1) / STEPS_PER_STG;

    logic [NSTG-1:0]       r_valid;
    logic [NSTG-1:0]       w_rdy;
    t_lane [NUM_LANES-1:0] r_lane [NSTG];
    logic [MAG_W-1:0]      r_rem  [NSTG-1][NUM_LANES];
    logic [MAG_W-1:0]      r_div  [NSTG-1];

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        logic                  in_valid;
        t_lane [NUM_LANES-1:0] in_lane;
        logic [MAG_W-1:0]      in_rem [NUM_LANES];
        logic [MAG_W-1:0]      in_div;
        t_lane [NUM_LANES-1:0] n_lane;
        logic [MAG_W-1:0]      n_rem  [NUM_LANES];

        if (s == 0) begin : g_head
            always_comb begin
                in_valid = i_valid;
                in_div   = i_norm.divisor;
                for (int l = 0; l < NUM_LANES; l++) begin
                    in_lane[l].neg = i_norm.lane[l].neg;
                    in_lane[l].mag = '0;
                    in_rem[l]      = i_norm.lane[l].mag;
                end
            end
        end else begin : g_body
            always_comb begin
                in_valid = r_valid[s-1];
                in_div   = r_div[s-1];
                in_lane  = r_lane[s-1];
                for (int l = 0; l < NUM_LANES; l++) begin
                    in_rem[l] = r_rem[s-1][l];
                end
            end
        end

        if (s == NSTG - 1) begin : g_last_rdy
            assign w_rdy[s] = !r_valid[s] || i_ready;
        end else begin : g_mid_rdy
            assign w_rdy[s] = !r_valid[s] || w_rdy[s+1];
        end

        // Up to STEPS_PER_STG quotient bits per stage, MSB first
        always_comb begin
            logic [MAG_W:0]   cand;
            logic [MAG_W-1:0] rem;
            logic [MAG_W-1:0] quo;
            for (int l = 0; l < NUM_LANES; l++) begin
                rem = in_rem[l];
                quo = in_lane[l].mag;
                for (int j = 0; j < STEPS_PER_STG; j++) begin
                    if (s * STEPS_PER_STG + j < NQ) begin
                        // the integer bit takes the magnitude unshifted
                        if (s * STEPS_PER_STG + j == 0) begin
                            cand = {1'b0, rem};
                        end else begin
                            cand = {rem, 1'b0};
                        end
                        if (cand >= {1'b0, in_div}) begin
                            cand = cand - {1'b0, in_div};
                            quo  = {quo[MAG_W-2:0], 1'b1};
                        end else begin
                            quo  = {quo[MAG_W-2:0], 1'b0};
                        end
                        rem = cand[MAG_W-1:0];
                    end
                end
                n_lane[l].neg = in_lane[l].neg;
                n_lane[l].mag = quo;
                n_rem[l]      = rem;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (w_rdy[s]) begin
                r_valid[s] <= in_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[s]) begin
                r_lane[s] <= n_lane;
            end
        end

        if (s < NSTG - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (w_rdy[s]) begin
                    r_div[s] <= in_div;
                    for (int l = 0; l < NUM_LANES; l++) begin
                        r_rem[s][l] <= n_rem[l];
                    end
                end
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_valid[NSTG-1];
    assign o_lane  = r_lane[NSTG-1];

endmodule

// File: rtl/xdm_back.sv
// ----------------------------------------------------------------------------
// X-drive mixer back end
// Form the four wheel fractions, scale by max voltage, truncate toward zero.
// ----------------------------------------------------------------------------
module xdm_back import xdm_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [VOLT_W-1:0]     i_max_voltage,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_lane [NUM_LANES-1:0] i_lane,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_volts                o_volts
);

    localparam int UNIT_W = FRAC_BITS + 2;
    localparam int PROD_W = UNIT_W + VOLT_W + 1;
    localparam logic signed [PROD_W-1:0] ROUND_ADJ = (PROD_W'(1) << FRAC_BITS) - PROD_W'(1);

    logic                     r_mix_valid;
    logic                     r_mul_valid;
    logic                     r_out_valid;
    logic                     w_mix_rdy;
    logic                     w_mul_rdy;
    logic                     w_out_rdy;
    logic signed [UNIT_W-1:0] r_unit [NUM_WHEELS];
    logic signed [UNIT_W-1:0] n_unit [NUM_WHEELS];
    logic signed [PROD_W-1:0] r_prod [NUM_WHEELS];
    logic signed [PROD_W-1:0] n_prod [NUM_WHEELS];
    logic signed [OUT_W-1:0]  r_out  [NUM_WHEELS];
    logic signed [OUT_W-1:0]  n_out  [NUM_WHEELS];
    logic signed [SUM_W-1:0]  w_val  [NUM_LANES];

    assign w_out_rdy = !r_out_valid || i_ready;
    assign w_mul_rdy = !r_mul_valid || w_out_rdy;
    assign w_mix_rdy = !r_mix_valid || w_mul_rdy;
    assign o_ready   = w_mix_rdy;

    // Sign, mix and clamp
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            w_val[l] = i_lane[l].neg ? -$signed({1'b0, i_lane[l].mag})
                                     :  $signed({1'b0, i_lane[l].mag});
        end
        n_unit[WHL_FL] = UNIT_W'(clamp_unit(w_val[LANE_LEFT]  + w_val[LANE_STRAFE], FRAC_BITS));
        n_unit[WHL_FR] = UNIT_W'(clamp_unit(w_val[LANE_RIGHT] - w_val[LANE_STRAFE], FRAC_BITS));
        n_unit[WHL_BR] = UNIT_W'(clamp_unit(w_val[LANE_RIGHT] + w_val[LANE_STRAFE], FRAC_BITS));
        n_unit[WHL_BL] = UNIT_W'(clamp_unit(w_val[LANE_LEFT]  - w_val[LANE_STRAFE], FRAC_BITS));
    end

    // Scale by full-scale voltage
    always_comb begin
        for (int w = 0; w < NUM_WHEELS; w++) begin
            n_prod[w] = PROD_W'(r_unit[w]) * $signed({1'b0, i_max_voltage});
        end
    end

    // Divide by 1.0, truncating toward zero
    always_comb begin
        logic signed [PROD_W-1:0] adj;
        for (int w = 0; w < NUM_WHEELS; w++) begin
            adj      = r_prod[w] + (r_prod[w][PROD_W-1] ? ROUND_ADJ : '0);
            n_out[w] = OUT_W'(adj >>> FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix_valid <= 1'b0;
            r_mul_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_mix_rdy) begin
                r_mix_valid <= i_valid;
            end
            if (w_mul_rdy) begin
                r_mul_valid <= r_mix_valid;
            end
            if (w_out_rdy) begin
                r_out_valid <= r_mul_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mix_rdy) begin
            r_unit <= n_unit;
        end
        if (w_mul_rdy) begin
            r_prod <= n_prod;
        end
        if (w_out_rdy) begin
            r_out <= n_out;
        end
    end

    assign o_valid                   = r_out_valid;
    assign o_volts.front_left_volts  = r_out[WHL_FL];
    assign o_volts.front_right_volts = r_out[WHL_FR];
    assign o_volts.back_right_volts  = r_out[WHL_BR];
    assign o_volts.back_left_volts   = r_out[WHL_BL];

endmodule
